// ===== hw/rtl/cc20_pkg.sv =====
// shared types, constants and round functions for the chacha20 stream cipher
`default_nettype none

package cc20_pkg;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int unsigned ROUNDS   = 20;
  localparam int unsigned ROUND_W  = $clog2(ROUNDS);
  localparam int unsigned CHUNKS   = 8;
  localparam int unsigned POS_W    = $clog2(CHUNKS);
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned REG_AW   = 6;

  // register indexes on the configuration port (paddr[5:3])
  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_KEY3  = 3'd3;
  localparam logic [2:0] REG_NONCE = 3'd4;
  localparam logic [2:0] REG_CTR   = 3'd5;

  typedef logic [15:0][31:0] words_t;
  typedef logic [3:0][31:0]  quad_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce;
    logic [63:0]      init_ctr;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic load;
    logic round;
    logic diag;
    logic finish;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_block;
  } sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic quad_t quarter(input quad_t q);
    logic [31:0] a, b, c, d;
    a = q[0]; b = q[1]; c = q[2]; d = q[3];
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    return {d, c, b, a};
  endfunction

  function automatic words_t build_init(input cfg_t cfg, input logic [63:0] ctr);
    words_t w;
    w[0] = SIGMA0; w[1] = SIGMA1; w[2] = SIGMA2; w[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      w[4 + 2*i] = cfg.key[i][31:0];
      w[5 + 2*i] = cfg.key[i][63:32];
    end
    w[12] = ctr[31:0];
    w[13] = ctr[63:32];
    w[14] = cfg.nonce[31:0];
    w[15] = cfg.nonce[63:32];
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cc20_ctrl.sv =====
// controller state machine: item intake, round sequencing and output hand-off
`default_nettype none

module cc20_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  input  wire cc20_pkg::sts_t sts,
  output cc20_pkg::cmd_t     cmd
);
  import cc20_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]         state, state_next;
  logic [ROUND_W-1:0] rnd, rnd_next;
  logic               m_tvalid_next;

  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take = 1'b1;
          if (sts.need_block) begin
            cmd.load   = 1'b1;
            rnd_next   = '0;
            state_next = ST_ROUND;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cmd.diag  = rnd[0];
        if (rnd == ROUND_W'(ROUNDS - 1)) begin
          state_next = ST_FIN;
        end else begin
          rnd_next = rnd + 1'b1;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    m_tvalid_next = cmd.emit | (m_tvalid & ~m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rnd      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      rnd      <= rnd_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cc20_dp.sv =====
// datapath: working state, four quarter-round lanes, keystream rows and output register
`default_nettype none

module cc20_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire cc20_pkg::cfg_t cfg,
  input  wire cc20_pkg::cmd_t cmd,
  output cc20_pkg::sts_t      sts,
  input  wire logic [63:0]    data_in,
  input  wire logic [3:0]     byte_count,
  input  wire logic           first_chunk,
  output logic [63:0]         data_out,
  output logic [3:0]          out_count
);
  import cc20_pkg::*;

  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  item_pos;
  logic [POS_W-1:0]  pos_eff;
  logic [63:0]       block_counter;
  logic [63:0]       ctr_sel;
  logic [63:0]       data_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_norm;
  words_t            work;
  words_t            work_next;
  words_t            init_w;
  logic [63:0]       ks [CHUNKS];
  logic [63:0]       mask;

  assign pos_eff        = first_chunk ? '0 : pos;
  assign sts.need_block = (pos_eff == '0);
  assign cnt_norm       = (byte_count == '0 || byte_count > CNT_W'(8)) ? CNT_W'(8) : byte_count;
  assign ctr_sel        = (cmd.take && first_chunk) ? cfg.init_ctr : block_counter;
  assign init_w         = build_init(cfg, ctr_sel);

  // column round on even steps, diagonal round on odd steps
  always_comb begin
    logic [3:0] ia, ib, ic, id;
    quad_t      q;
    work_next = work;
    for (int i = 0; i < 4; i++) begin
      ia = 4'(i);
      ib = cmd.diag ? 4'(4 + ((i + 1) % 4))  : 4'(4 + i);
      ic = cmd.diag ? 4'(8 + ((i + 2) % 4))  : 4'(8 + i);
      id = cmd.diag ? 4'(12 + ((i + 3) % 4)) : 4'(12 + i);
      q  = quarter({work[id], work[ic], work[ib], work[ia]});
      work_next[ia] = q[0];
      work_next[ib] = q[1];
      work_next[ic] = q[2];
      work_next[id] = q[3];
    end
  end

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[8*b +: 8] = (CNT_W'(b) < cnt_r) ? 8'hff : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      block_counter <= '0;
    end else begin
      if (cmd.take && first_chunk) begin
        block_counter <= cfg.init_ctr;
      end else if (cmd.finish) begin
        block_counter <= block_counter + 64'd1;
      end
      if (cmd.emit) begin
        pos <= (cnt_r < CNT_W'(8)) ? '0 : item_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      data_r   <= data_in;
      cnt_r    <= cnt_norm;
      item_pos <= pos_eff;
    end
    if (cmd.load) begin
      work <= init_w;
    end else if (cmd.round) begin
      work <= work_next;
    end
    if (cmd.finish) begin
      for (int j = 0; j < CHUNKS; j++) begin
        ks[j] <= {work[2*j+1] + init_w[2*j+1], work[2*j] + init_w[2*j]};
      end
    end
    if (cmd.emit) begin
      data_out  <= (data_r ^ ks[item_pos]) & mask;
      out_count <= cnt_r;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/chacha20_stream_cipher.sv =====
// chacha20 stream cipher top level: register port, controller and datapath
//
// usage
//   s_* channel takes one 8-byte chunk per item; s_tuser set starts a message
//   and reloads the block counter from initial_counter. byte_count 1 to 7 ends
//   the message; the next chunk then starts a fresh keystream block.
//   m_* channel returns one item per input: xored bytes, unused upper bytes zero.
//   apb port writes key, nonce and initial counter; write only while idle.
// sequence
//   chunk mid-block: the result is registered from the emit state once the output register is free.
//   chunk on a 64-byte boundary: the state is loaded at acceptance, then 20 rounds run
//   through four parallel quarter-round lanes, then the state add-back, then the output register.
//   one item in flight; the next item is taken the cycle after its result is loaded.
// reset and stall
//   reset clears block counter, chunk position and output valid; keystream
//   rows need no clearing since a block is always built before its first use.
//   while m_tready is low the result holds and one more item may be accepted,
//   which then waits until the output register frees.
`default_nettype none

module chacha20_stream_cipher (
  input  wire logic        clk,
  input  wire logic        rst,
  // apb register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  // input chunks
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // data_in [63:0], byte_count [67:64], zero pad [71:68]
  input  wire logic        s_tuser,  // first_chunk [0]
  // output chunks
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata   // data_out [63:0], out_count [67:64], zero pad [71:68]
);
  import cc20_pkg::*;

  cfg_t        cfg;
  cmd_t        cmd;
  sts_t        sts;
  logic        cfg_wr;
  logic [2:0]  reg_idx;
  logic [63:0] data_out;
  logic [3:0]  out_count;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_KEY0:  cfg.key[0]   <= pwdata;
        REG_KEY1:  cfg.key[1]   <= pwdata;
        REG_KEY2:  cfg.key[2]   <= pwdata;
        REG_KEY3:  cfg.key[3]   <= pwdata;
        REG_NONCE: cfg.nonce    <= pwdata;
        REG_CTR:   cfg.init_ctr <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY0:  prdata = cfg.key[0];
      REG_KEY1:  prdata = cfg.key[1];
      REG_KEY2:  prdata = cfg.key[2];
      REG_KEY3:  prdata = cfg.key[3];
      REG_NONCE: prdata = cfg.nonce;
      REG_CTR:   prdata = cfg.init_ctr;
      default:   prdata = '0;
    endcase
  end

  cc20_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cc20_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .data_in     (s_tdata[63:0]),
    .byte_count  (s_tdata[67:64]),
    .first_chunk (s_tuser),
    .data_out    (data_out),
    .out_count   (out_count)
  );

  assign m_tdata = {4'b0000, out_count, data_out};

  // one item at a time: intake closes right after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on two consecutive cycles");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[67:64] >= 4'd1) && (m_tdata[67:64] <= 4'd8))
    else $error("output byte count out of range");

  a_tail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[67:64] < 4'd8) |-> ((m_tdata[63:0] >> (8 * m_tdata[67:64])) == 64'd0))
    else $error("bytes beyond the count not zero");

  // a new result only appears when the previous one was taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("pending result lost");

endmodule

`default_nettype wire

// ===== tb/sv/chacha20_stream_cipher_checker.sv =====
// checker for the chacha20 stream cipher: tracks registers, predicts ciphertext items, compares
module chacha20_stream_cipher_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,  // data_in [63:0], byte_count [67:64], zero pad [71:68]
  input  logic        s_tuser,  // first_chunk [0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,  // data_out [63:0], out_count [67:64], zero pad [71:68]
  output int          errors,
  output int          pending
);
  import cc20_pkg::*;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
  } cipher_item_t;

  cipher_item_t ciphertext_q[$];

  logic [63:0] key_reg [4];
  logic [63:0] nonce_reg;
  logic [63:0] start_ctr;
  logic [63:0] block_ctr;
  logic [2:0]  chunk_pos;
  words_t      keystream;

  function automatic logic [31:0] spin(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic words_t qround(input words_t w, input int unsigned a, b, c, d);
    w[a] = w[a] + w[b];  w[d] = spin(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d];  w[b] = spin(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b];  w[d] = spin(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d];  w[b] = spin(w[b] ^ w[c], 7);
    return w;
  endfunction

  function automatic words_t keystream_block(input logic [63:0] ctr);
    words_t seed;
    words_t w;
    seed[0] = SIGMA0;
    seed[1] = SIGMA1;
    seed[2] = SIGMA2;
    seed[3] = SIGMA3;
    for (int k = 0; k < 4; k++) begin
      seed[4 + 2*k] = key_reg[k][31:0];
      seed[5 + 2*k] = key_reg[k][63:32];
    end
    seed[13:12] = ctr;
    seed[15:14] = nonce_reg;
    w = seed;
    for (int r = 0; r < 10; r++) begin
      w = qround(w, 0, 4, 8, 12);
      w = qround(w, 1, 5, 9, 13);
      w = qround(w, 2, 6, 10, 14);
      w = qround(w, 3, 7, 11, 15);
      w = qround(w, 0, 5, 10, 15);
      w = qround(w, 1, 6, 11, 12);
      w = qround(w, 2, 7, 8, 13);
      w = qround(w, 3, 4, 9, 14);
    end
    for (int k = 0; k < 16; k++) w[k] = w[k] + seed[k];
    return w;
  endfunction

  task automatic encrypt_chunk(input logic [71:0] tdata, input logic first);
    logic [3:0]   n;
    logic [63:0]  ks;
    logic [63:0]  keep;
    cipher_item_t item;
    n = tdata[67:64];
    // out-of-range counts behave as a full chunk
    if (n == 4'd0 || n > 4'd8) n = 4'd8;
    if (first) begin
      block_ctr = start_ctr;
      chunk_pos = '0;
    end
    if (chunk_pos == 3'd0) begin
      keystream = keystream_block(block_ctr);
      block_ctr = block_ctr + 64'd1;
    end
    ks = {keystream[2*chunk_pos + 1], keystream[2*chunk_pos]};
    keep = (n == 4'd8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    item.data = (tdata[63:0] ^ ks) & keep;
    item.count = n;
    ciphertext_q.push_back(item);
    // a short chunk ends the message and drops the rest of the block
    chunk_pos = (n < 4'd8) ? 3'd0 : chunk_pos + 3'd1;
  endtask

  task automatic check_output(input logic [71:0] tdata);
    cipher_item_t want;
    if (ciphertext_q.size() == 0) begin
      $error("output item with nothing expected: data_out %h out_count %0d",
             tdata[63:0], tdata[67:64]);
      errors++;
    end else begin
      want = ciphertext_q.pop_front();
      if (tdata[63:0] !== want.data) begin
        $error("data_out mismatch: expected %h, actual %h", want.data, tdata[63:0]);
        errors++;
      end
      if (tdata[67:64] !== want.count) begin
        $error("out_count mismatch: expected %0d, actual %0d", want.count, tdata[67:64]);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) key_reg[k] = '0;
      nonce_reg = '0;
      start_ctr = '0;
      block_ctr = '0;
      chunk_pos = '0;
      ciphertext_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_KEY0:  key_reg[0] = pwdata;
          REG_KEY1:  key_reg[1] = pwdata;
          REG_KEY2:  key_reg[2] = pwdata;
          REG_KEY3:  key_reg[3] = pwdata;
          REG_NONCE: nonce_reg = pwdata;
          REG_CTR:   start_ctr = pwdata;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) check_output(m_tdata);
      if (s_tvalid && s_tready) encrypt_chunk(s_tdata, s_tuser);
    end
    pending = ciphertext_q.size();
  end

endmodule

// ===== tb/sv/chacha20_stream_cipher_test.sv =====
// top of the chacha20 stream cipher testbench: clock, reset, register setup, chunk stimulus
module chacha20_stream_cipher_test;
  import cc20_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 180;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam int unsigned HOLD_CYCLES = 400;

  // counts for the directed part: two blocks across the counter wrap, odd counts,
  // tails back to back and a restart straight after a short tail
  localparam logic [3:0] DIRECTED_COUNTS [25] = '{
    4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
    4'd0, 4'd9, 4'd15, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14,
    4'd3, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd8
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // data_in [63:0], byte_count [67:64], zero pad [71:68]
  logic        s_tuser;   // first_chunk [0]
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // data_out [63:0], out_count [67:64], zero pad [71:68]

  int errors;
  int pending;
  int items_sent;
  int burst_left;
  int quiet;
  bit long_hold_done;

  chacha20_stream_cipher DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  chacha20_stream_cipher_checker chk (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("chacha20_stream_cipher_test: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // receiver: changing stall patterns, plus one long hold-off
  initial begin
    int mode;
    int span;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (!long_hold_done && items_sent >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      repeat (span) begin
        case (mode)
          0:       m_tready = 1'b1;
          1:       m_tready = 1'($urandom_range(0, 1));
          2:       m_tready = ($urandom_range(0, 4) == 0);
          default: m_tready = ($urandom_range(0, 4) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  function automatic logic [63:0] random_data();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // kind 0: all zero, 1: all ones, otherwise random key and nonce
  task automatic load_setting(input int kind, input logic [63:0] ctr);
    logic [63:0] word;
    for (int k = 0; k < 4; k++) begin
      word = (kind == 0) ? '0 : (kind == 1) ? '1 : {$urandom, $urandom};
      reg_write(REG_KEY0 + 3'(k), word);
    end
    word = (kind == 0) ? '0 : (kind == 1) ? '1 : {$urandom, $urandom};
    reg_write(REG_NONCE, word);
    reg_write(REG_CTR, ctr);
  endtask

  task automatic send_chunk(input logic [63:0] data, input logic [3:0] n, input logic first);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = {4'b0000, n, data};
    s_tuser = first;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // a message: full chunks, mostly a short tail, mostly opened with the first flag
  task automatic send_message();
    int n;
    logic [3:0] cnt;
    logic lead;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 10);
    lead = ($urandom_range(0, 9) != 0);
    for (int k = 0; k < n; k++) begin
      cnt = 4'd8;
      if (k == n - 1 && $urandom_range(0, 2) != 0) cnt = 4'($urandom_range(1, 7));
      send_chunk(random_data(), cnt, lead && k == 0);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_chunk(random_data(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int target;
    logic [63:0] ctr;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    items_sent = 0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no first flag straight after reset: block counter starts at zero
    send_chunk(random_data(), 4'd8, 1'b0);
    send_chunk(random_data(), 4'd5, 1'b0);
    drain();

    load_setting(2, 64'hFFFF_FFFF_FFFF_FFFE);
    for (int i = 0; i < 25; i++)
      send_chunk((i % 3 == 0) ? 64'd0 : (i % 3 == 1) ? '1 : random_data(),
                 DIRECTED_COUNTS[i], i == 0 || i == 20);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       ctr = '0;
        1:       ctr = '1;
        2:       ctr = 64'h0000_0000_FFFF_FFFE;
        3:       ctr = 64'hFFFF_FFFF_FFFF_FFFC;
        default: ctr = {$urandom, $urandom};
      endcase
      load_setting((ph < 2) ? ph : 2, ctr);
      // new key while the stream is part way through a block
      if (ph == 0) send_chunk(random_data(), 4'd8, 1'b0);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 7) == 0) send_noise();
        else send_message();
      end
      drain();
    end

    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("chacha20_stream_cipher_test: done, clean");
    end else begin
      $display("chacha20_stream_cipher_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cc20_pkg.sv
hw/rtl/cc20_ctrl.sv
hw/rtl/cc20_dp.sv
hw/rtl/chacha20_stream_cipher.sv
tb/sv/chacha20_stream_cipher_checker.sv
tb/sv/chacha20_stream_cipher_test.sv
